>>> hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: periodic transmit scheduler package
// Request and status codes, the table entry type and fixed result limits.
// ----------------------------------------------------------------------------
package pts_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_DUE       = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_ADDED     = 3'd2,
    STAT_REMOVED   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_NONE_DUE  = 3'd6
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // one table entry as it travels along the chain
  typedef struct packed {
    logic [7:0]  sidx;
    logic [7:0]  vidx;
    logic [31:0] ival;
    logic [31:0] lfire;
  } entry_t;

  // due results reported by one tick at most
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NresW      = $clog2(MaxResults + 1);
  typedef logic [NresW-1:0] nres_t;

endpackage

>>> hdl/pts_req_if.sv
// ----------------------------------------------------------------------------
// pts_req_if: request channel
// Valid/ready channel carrying one scheduler request.
// ----------------------------------------------------------------------------
interface pts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  struct_index;
  logic [7:0]  variable_index;
  logic [31:0] interval_ms;
  logic [31:0] now_ms;

  modport source (
    output valid, req_type, struct_index, variable_index, interval_ms, now_ms,
    input  ready
  );
  modport sink (
    input  valid, req_type, struct_index, variable_index, interval_ms, now_ms,
    output ready
  );
endinterface

>>> hdl/pts_rsp_if.sv
// ----------------------------------------------------------------------------
// pts_rsp_if: result channel
// Valid/ready channel carrying one scheduler result.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] due_struct;
  logic [7:0] due_variable;
  logic       last;

  modport source (
    output valid, status, due_struct, due_variable, last,
    input  ready
  );
  modport sink (
    input  valid, status, due_struct, due_variable, last,
    output ready
  );
endinterface

>>> hdl/periodic_transmit_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_transmit_scheduler: periodic transmit table scheduler
// Start, stop and tick requests on a circulating table of periodic entries.
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  req_i    in   sink     req_type, struct_index, variable_index,
//                         interval_ms, now_ms
//  rsp_o    out  source   status, due_struct, due_variable, last
//
//  each request is accepted in idle, then makes one full turn of the entry
//  ring (TABLE_DEPTH shifts past the head unit), then posts the final result.
//  a stalled result port stops the ring while a tick holds a due result it
//  cannot place, and holds the final step until the result register frees.
//  reset clears the control registers and the entry count; the slots need no
//  clearing pass. a new request is taken while the last result waits.
// ----------------------------------------------------------------------------
module periodic_transmit_scheduler #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o
);
  import pts_pkg::*;

  localparam int unsigned KW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] TableDepthC = CW'(TABLE_DEPTH);
  localparam logic [KW-1:0] LastSlotC   = KW'(TABLE_DEPTH - 1);

  state_e        state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d;
  nres_t         nres_q, nres_d;
  logic          pend_vld_q, pend_vld_d;
  logic [7:0]    pend_s_q, pend_s_d, pend_v_q, pend_v_d;
  logic          out_vld_q, out_vld_d;
  status_e       out_stat_q, out_stat_d;
  logic [7:0]    out_s_q, out_s_d, out_v_q, out_v_d;
  logic          out_last_q, out_last_d;

  req_e          rq_type_q;
  logic [7:0]    rq_s_q, rq_v_q;
  logic [31:0]   rq_ival_q, rq_now_q;

  logic          cap;
  logic          shift;
  entry_t        head, nxt, tail;
  logic          in_tbl, key_hit, at_end, due, out_free;
  logic [31:0]   elapsed;

  // entry ring
  pts_ring #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .shift_i (shift),
    .tail_i  (tail),
    .head_o  (head),
    .next_o  (nxt)
  );

  // head unit tests
  assign in_tbl   = CW'(k_q) < cnt_q;
  assign at_end   = CW'(k_q) == cnt_q;
  assign key_hit  = in_tbl && (head.sidx == rq_s_q) && (head.vidx == rq_v_q);
  assign elapsed  = rq_now_q - head.lfire;
  assign due      = in_tbl && (elapsed >= head.ival) && (nres_q < nres_t'(MaxResults));
  assign out_free = !out_vld_q || rsp_o.ready;

  // sequencer and head processing
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    nres_d     = nres_q;
    pend_vld_d = pend_vld_q;
    pend_s_d   = pend_s_q;
    pend_v_d   = pend_v_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_stat_d = out_stat_q;
    out_s_d    = out_s_q;
    out_v_d    = out_v_q;
    out_last_d = out_last_q;
    cap        = 1'b0;
    shift      = 1'b0;
    tail       = head;
    req_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cap = 1'b1;
          if (req_i.req_type inside {REQ_START, REQ_STOP, REQ_TICK}) begin
            state_d = S_SCAN;
            k_d     = '0;
          end
        end
      end

      S_SCAN: begin
        shift = 1'b1;
        case (rq_type_q)
          REQ_START: begin
            if (key_hit) begin
              tail.ival = rq_ival_q;
              found_d   = 1'b1;
            end else if (at_end && !found_q) begin
              tail = '{sidx: rq_s_q, vidx: rq_v_q, ival: rq_ival_q, lfire: rq_now_q};
            end
          end
          REQ_STOP: begin
            // from the match on, each slot takes its successor
            if (key_hit || found_q) begin
              tail = nxt;
            end
            if (key_hit) begin
              found_d = 1'b1;
            end
          end
          REQ_TICK: begin
            if (due) begin
              if (pend_vld_q && !out_free) begin
                shift = 1'b0;
              end else begin
                tail.lfire = head.lfire + head.ival;
                nres_d     = nres_q + 1'b1;
                pend_vld_d = 1'b1;
                pend_s_d   = head.sidx;
                pend_v_d   = head.vidx;
                if (pend_vld_q) begin
                  out_vld_d  = 1'b1;
                  out_stat_d = STAT_DUE;
                  out_s_d    = pend_s_q;
                  out_v_d    = pend_v_q;
                  out_last_d = 1'b0;
                end
              end
            end
          end
          default: ;
        endcase
        if (shift) begin
          if (k_q == LastSlotC) begin
            state_d = S_DONE;
            k_d     = '0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d    = S_IDLE;
          found_d    = 1'b0;
          nres_d     = '0;
          pend_vld_d = 1'b0;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          out_s_d    = rq_s_q;
          out_v_d    = rq_v_q;
          case (rq_type_q)
            REQ_START: begin
              if (found_q) begin
                out_stat_d = STAT_UPDATED;
              end else if (cnt_q != TableDepthC) begin
                out_stat_d = STAT_ADDED;
                cnt_d      = cnt_q + 1'b1;
              end else begin
                out_stat_d = STAT_FULL;
              end
            end
            REQ_STOP: begin
              if (found_q) begin
                out_stat_d = STAT_REMOVED;
                cnt_d      = cnt_q - 1'b1;
              end else begin
                out_stat_d = STAT_NOT_FOUND;
              end
            end
            REQ_TICK: begin
              if (pend_vld_q) begin
                out_stat_d = STAT_DUE;
                out_s_d    = pend_s_q;
                out_v_d    = pend_v_q;
              end else begin
                out_stat_d = STAT_NONE_DUE;
                out_s_d    = '0;
                out_v_d    = '0;
              end
            end
            default: begin
              out_vld_d = out_vld_q && !rsp_o.ready;
            end
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      cnt_q      <= '0;
      found_q    <= 1'b0;
      nres_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      cnt_q      <= cnt_d;
      found_q    <= found_d;
      nres_q     <= nres_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (cap) begin
      rq_type_q <= req_e'(req_i.req_type);
      rq_s_q    <= req_i.struct_index;
      rq_v_q    <= req_i.variable_index;
      rq_ival_q <= req_i.interval_ms;
      rq_now_q  <= req_i.now_ms;
    end
    pend_s_q   <= pend_s_d;
    pend_v_q   <= pend_v_d;
    out_stat_q <= out_stat_d;
    out_s_q    <= out_s_d;
    out_v_q    <= out_v_d;
    out_last_q <= out_last_d;
  end

  // result port
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.due_struct   = out_s_q;
  assign rsp_o.due_variable = out_v_q;
  assign rsp_o.last         = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TableDepthC)
    else $error("entry count beyond table depth");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == S_SCAN || state_q == S_DONE))
    else $error("held due result outside a tick");

  a_nres_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= nres_t'(MaxResults))
    else $error("due result count beyond limit");

  a_final_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_vld_q && out_last_q && state_q == S_IDLE))
    else $error("final result not posted");
`endif

endmodule

>>> hdl/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell: one table slot
// Holds one entry and loads the entry at its input on every shift.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  pts_pkg::entry_t d_i,
  output pts_pkg::entry_t q_o
);
  import pts_pkg::*;

  entry_t ent_q;

  // slot storage, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q <= d_i;
    end
  end

  assign q_o = ent_q;

endmodule

>>> hdl/pts_ring.sv
// ----------------------------------------------------------------------------
// pts_ring: circulating entry chain
// Row of slots that shifts toward the head; the tail takes the processed entry.
// ----------------------------------------------------------------------------
module pts_ring #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            shift_i,
  input  pts_pkg::entry_t tail_i,
  output pts_pkg::entry_t head_o,
  output pts_pkg::entry_t next_o
);
  import pts_pkg::*;

  localparam int unsigned NextIdx = (TABLE_DEPTH > 1) ? 1 : 0;

  entry_t slot [TABLE_DEPTH];

  // chain of cells, each fed by its upstream neighbor, the last by the tail input
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t d;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign d = tail_i;
    end else begin : g_mid
      assign d = slot[i+1];
    end
    pts_cell u_cell (
      .clk_i (clk_i),
      .en_i  (shift_i),
      .d_i   (d),
      .q_o   (slot[i])
    );
  end

  assign head_o = slot[0];
  assign next_o = slot[NextIdx];

endmodule

>>> dv/periodic_transmit_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_transmit_scheduler_checker: result scoreboard for the scheduler
// Watches both channels, keeps its own copy of the entry table, works out the
// results of every accepted request and compares them in order, field by field.
// ----------------------------------------------------------------------------
module periodic_transmit_scheduler_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pts_req_if          req_mon,
  pts_rsp_if          rsp_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import pts_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [7:0] sidx;
    logic [7:0] vidx;
    logic       last;
  } sched_result_t;

  entry_t        sched_tab [TABLE_DEPTH];
  int unsigned   live_cnt = 0;
  sched_result_t result_q [$];
  int unsigned   fails = 0;

  task automatic push_result(input status_e st, input logic [7:0] sidx, vidx,
                             input logic lst);
    sched_result_t r;
    r.status = st;
    r.sidx   = sidx;
    r.vidx   = vidx;
    r.last   = lst;
    result_q.push_back(r);
  endtask

  // apply one request to the shadow table and queue what it must produce
  task automatic predict_request(input logic [1:0] kind, input logic [7:0] sidx, vidx,
                                 input logic [31:0] ival, now);
    int            hit;
    int unsigned   i;
    int unsigned   n_due;
    logic [31:0]   elapsed;
    sched_result_t tail;
    hit = -1;
    for (i = 0; i < live_cnt; i++) begin
      if (hit < 0 && sched_tab[i].sidx == sidx && sched_tab[i].vidx == vidx) hit = int'(i);
    end
    case (kind)
      REQ_START: begin
        if (hit >= 0) begin
          sched_tab[hit].ival = ival;
          push_result(STAT_UPDATED, sidx, vidx, 1'b1);
        end else if (live_cnt < TABLE_DEPTH) begin
          sched_tab[live_cnt].sidx  = sidx;
          sched_tab[live_cnt].vidx  = vidx;
          sched_tab[live_cnt].ival  = ival;
          sched_tab[live_cnt].lfire = now;
          live_cnt++;
          push_result(STAT_ADDED, sidx, vidx, 1'b1);
        end else begin
          push_result(STAT_FULL, sidx, vidx, 1'b1);
        end
      end
      REQ_STOP: begin
        if (hit >= 0) begin
          // close the gap, keeping insertion order
          for (i = unsigned'(hit); i + 1 < live_cnt; i++) sched_tab[i] = sched_tab[i + 1];
          live_cnt--;
          push_result(STAT_REMOVED, sidx, vidx, 1'b1);
        end else begin
          push_result(STAT_NOT_FOUND, sidx, vidx, 1'b1);
        end
      end
      REQ_TICK: begin
        n_due = 0;
        for (i = 0; i < live_cnt && n_due < MaxResults; i++) begin
          // elapsed time wraps modulo 2^32
          elapsed = now - sched_tab[i].lfire;
          if (elapsed >= sched_tab[i].ival) begin
            sched_tab[i].lfire = sched_tab[i].lfire + sched_tab[i].ival;
            push_result(STAT_DUE, sched_tab[i].sidx, sched_tab[i].vidx, 1'b0);
            n_due++;
          end
        end
        if (n_due == 0) begin
          push_result(STAT_NONE_DUE, 8'h00, 8'h00, 1'b1);
        end else begin
          tail      = result_q.pop_back();
          tail.last = 1'b1;
          result_q.push_back(tail);
        end
      end
      default: ;  // unused request type: no change, no result
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // compare results first, then take in the request of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      live_cnt = 0;
      result_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (result_q.size() == 0) begin
          $error("result with none expected: status %0d, struct %0d, variable %0d",
                 rsp_mon.status, rsp_mon.due_struct, rsp_mon.due_variable);
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_mon.status));
          check_field("due_struct", 32'(want.sidx), 32'(rsp_mon.due_struct));
          check_field("due_variable", 32'(want.vidx), 32'(rsp_mon.due_variable));
          check_field("last", 32'(want.last), 32'(rsp_mon.last));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_request(req_mon.req_type, req_mon.struct_index, req_mon.variable_index,
                        req_mon.interval_ms, req_mon.now_ms);
      end
      pending_o    <= result_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> dv/periodic_transmit_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_transmit_scheduler_test: testbench top for the scheduler
// Drives start, stop and tick requests, first a directed set around the table
// edges and time wrap, then random request streams over a small key pool under
// varying back-pressure. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module periodic_transmit_scheduler_test;
  import pts_pkg::*;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 4 * (TableDepth + 2);
  localparam int unsigned KeyPool      = 20;
  localparam logic [1:0]  ReqUnused    = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_cnt    = 0;
  int unsigned src_idle_pct = 0;
  int unsigned rsp_idle_pct = 0;
  logic        hold_rsp     = 1'b0;
  logic [31:0] wall_ms;
  logic [15:0] key_pool [KeyPool];

  pts_req_if req_ch ();
  pts_rsp_if rsp_ch ();

  periodic_transmit_scheduler #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  periodic_transmit_scheduler_checker #(
    .TABLE_DEPTH(TableDepth)
  ) sched_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result receiver: random stalls, plus one long hold-off on demand
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // offer one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] kind, input logic [7:0] sidx, vidx,
                              input logic [31:0] ival, now);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.struct_index   <= sidx;
    req_ch.variable_index <= vidx;
    req_ch.interval_ms    <= ival;
    req_ch.now_ms         <= now;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // stop offering until every queued result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly well-formed traffic on the key pool with a rising clock,
  // some keys off the pool, out-of-order times and unused request types
  task automatic run_random(input int unsigned count);
    int unsigned done_cnt;
    int unsigned pick;
    logic [15:0] key;
    logic [31:0] ival;
    done_cnt = 0;
    while (done_cnt < count) begin
      pick = $urandom_range(99);
      key  = ($urandom_range(9) == 0) ? 16'($urandom) : key_pool[$urandom_range(KeyPool - 1)];
      ival = ($urandom_range(7) == 0) ? $urandom : $urandom_range(60);
      if (pick < 5) begin
        send_request(ReqUnused, key[15:8], key[7:0], $urandom, $urandom);
      end else begin
        done_cnt++;
        if (pick < 40) begin
          if ($urandom_range(19) == 0) begin
            send_request(REQ_TICK, key[15:8], key[7:0], ival, $urandom);
          end else begin
            wall_ms = wall_ms + $urandom_range(40);
            send_request(REQ_TICK, key[15:8], key[7:0], ival, wall_ms);
          end
        end else if (pick < 75) begin
          send_request(REQ_START, key[15:8], key[7:0], ival, wall_ms);
        end else begin
          send_request(REQ_STOP, key[15:8], key[7:0], ival, $urandom);
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int k;
    rst_ni                <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_START;
    req_ch.struct_index   <= 8'h00;
    req_ch.variable_index <= 8'h00;
    req_ch.interval_ms    <= 32'h0;
    req_ch.now_ms         <= 32'h0;
    for (k = 0; k < KeyPool; k++) key_pool[k] = 16'($urandom);
    wall_ms = 32'hFFFF_FF00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles often, receiver idles most of the time
    src_idle_pct = 24;
    rsp_idle_pct = 75;

    // empty table: tick with nothing due, stop of an unknown entry
    send_request(REQ_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_STOP, 8'h00, 8'h00, 32'h0, 32'h0);
    // add at both index extremes, then update the first
    send_request(REQ_START, 8'h00, 8'h00, 32'h0, 32'h0);
    send_request(REQ_START, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_START, 8'h00, 8'h00, 32'd5, 32'h1234_5678);
    // due at the top of time, then again across the wrap
    send_request(REQ_TICK, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 8'h00, 8'h00, 32'h0, 32'h0000_0004);
    send_request(ReqUnused, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero interval entry, then remove from the middle
    send_request(REQ_START, 8'hA5, 8'h5A, 32'h0, 32'd7);
    send_request(REQ_STOP, 8'hFF, 8'hFF, 32'h0, 32'h0);
    // fill the table so a tick reports the most results at once
    for (k = 0; k < TableDepth - 2; k++) begin
      send_request(REQ_START, key_pool[k][15:8], key_pool[k][7:0], 32'h0, 32'h0);
    end
    send_request(REQ_TICK, 8'h00, 8'h00, 32'h0, 32'h8000_0000);
    // update on a full table, add to a full table, remove the second entry
    send_request(REQ_START, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_START, 8'h12, 8'h34, 32'd9, 32'h0);
    send_request(REQ_STOP, 8'hA5, 8'h5A, 32'h0, 32'h0);

    run_random(32);
    wait_drained();

    // receiver idles often, sender idles most of the time
    src_idle_pct = 75;
    rsp_idle_pct = 24;
    run_random(32);
    wait_drained();

    // no idling; one long receiver hold-off while ticks keep coming
    src_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_rsp = 1'b1;
    for (k = 0; k < 12; k++) begin
      wall_ms = wall_ms + $urandom_range(40);
      send_request(REQ_TICK, 8'($urandom), 8'($urandom), $urandom, wall_ms);
    end
    run_random(28);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
